>>> rtl/core/pmd_pkg.sv
// pmd_pkg: shared widths, constants, register indexes and beat types
// for the pid_motor_drive block and its sub-units
// no dependencies
package pmd_pkg;

    // fixed point position of the binary point (Q16.16 by default)
    localparam int FRAC_BITS_DEFAULT = 16;

    // field and datapath widths
    localparam int MAG_W       = 32;
    localparam int ERR_W       = 33;
    localparam int DIFF_W      = 34;
    localparam int PERIOD_W    = 31;
    localparam int FRICTION_W  = 26;
    localparam int DRIVE_W     = 27;
    localparam int PWM_W       = 10;
    localparam int DRIVE_INT_W = 10;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // integer parts of the integral and drive limits
    localparam int INTEG_LIMIT_INT = 100;
    localparam int DRIVE_LIMIT_INT = 999;

    localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RESET = 31'd655;

    // derivative magnitude saturates here (2^31)
    localparam logic [MAG_W-1:0] QUOT_SAT = 32'h8000_0000;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_I    = 3'd1,
        REG_GAIN_D    = 3'd2,
        REG_FRICTION  = 3'd3,
        REG_PERIOD    = 3'd4
    } cfg_reg_t;

    // input beat
    typedef struct packed {
        logic signed [31:0] measured_position;
        logic signed [31:0] target_position;
    } in_item_t;

    // output beat
    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive_value;
        logic [PWM_W-1:0]          pwm_duty;
        logic                      dir_forward;
        logic                      dir_reverse;
    } out_item_t;

    // one multiply-accumulate request to the shared unit
    typedef struct packed {
        logic             valid;
        logic             clear;
        logic             neg;
        logic [MAG_W-1:0] a;
        logic [MAG_W-1:0] b;
    } mac_op_t;

endpackage

>>> rtl/core/pmd_div.sv
// pmd_div: restoring serial divider for the derivative term, one quotient bit a cycle
// depends on pmd_pkg
module pmd_div
    import pmd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIFF_W-1:0]   dividend_mag,
    input  logic [PERIOD_W-1:0] divisor,
    output logic                done,
    output logic [MAG_W-1:0]    quotient
);

    localparam int DvdW  = DIFF_W + FRAC_BITS;
    localparam int QBits = MAG_W + 1;
    localparam int CntW  = $clog2(QBits + 1);

    logic [PERIOD_W-1:0] rem_reg;
    logic [PERIOD_W-1:0] dvs_reg;
    logic [QBits-1:0]    low_reg;
    logic [QBits-1:0]    q_reg;
    logic                ovf_reg;
    logic [CntW-1:0]     count_reg;
    logic                done_reg;

    logic [DvdW-1:0]       dividend;
    logic [DvdW-QBits-1:0] high;
    logic [PERIOD_W-1:0]   dvs_start;
    logic [PERIOD_W:0]     trial;
    logic [PERIOD_W:0]     trial_sub;
    logic                  ge;
    logic [PERIOD_W-1:0]   rem_next;

    // scaled dividend, upper part checked for quotient overflow up front
    assign dividend  = {dividend_mag, {FRAC_BITS{1'b0}}};
    assign high      = dividend[DvdW-1:QBits];
    assign dvs_start = (divisor == '0) ? PERIOD_W'(1) : divisor;

    // one restoring step
    assign trial     = {rem_reg, low_reg[QBits-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign ge        = (trial >= {1'b0, dvs_reg});
    assign rem_next  = ge ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];

    // iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else if (start)
        begin
            count_reg <= CntW'(QBits);
            done_reg  <= 1'b0;
        end
        else if (count_reg != '0)
        begin
            count_reg <= count_reg - 1'b1;
            if (count_reg == CntW'(1))
            begin
                done_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= PERIOD_W'(high);
            dvs_reg <= dvs_start;
            low_reg <= dividend[QBits-1:0];
            q_reg   <= '0;
            ovf_reg <= (PERIOD_W'(high) >= dvs_start);
        end
        else if (count_reg != '0)
        begin
            rem_reg <= rem_next;
            low_reg <= {low_reg[QBits-2:0], 1'b0};
            q_reg   <= {q_reg[QBits-2:0], ge};
        end
    end

    // saturate the magnitude at 2^31
    assign done     = done_reg;
    assign quotient = (ovf_reg || (q_reg > {1'b0, QUOT_SAT})) ? QUOT_SAT : q_reg[MAG_W-1:0];

endmodule

>>> rtl/core/pmd_mac.sv
// pmd_mac: shared 32x32 multiplier with fixed point scaling and a wide accumulator
// depends on pmd_pkg
module pmd_mac
    import pmd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
    parameter int ACC_W     = 2 * MAG_W - FRAC_BITS + 3
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mac_op_t                 op,
    input  logic signed [ACC_W-1:0] init,
    output logic signed [ACC_W-1:0] acc
);

    logic [2*MAG_W-1:0]      prod_reg;
    logic                    valid1_reg;
    logic                    clear1_reg;
    logic                    neg1_reg;
    logic signed [ACC_W-1:0] init1_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic [ACC_W-1:0]        term;
    logic signed [ACC_W-1:0] term_signed;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] acc_next;

    // stage 1: magnitude product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= op.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= (2 * MAG_W)'(op.a) * (2 * MAG_W)'(op.b);
        clear1_reg <= op.clear;
        neg1_reg   <= op.neg;
        init1_reg  <= init;
    end

    // stage 2: drop fraction bits (toward zero), apply sign, accumulate
    assign term        = ACC_W'(prod_reg >> FRAC_BITS);
    assign term_signed = neg1_reg ? -signed'(term) : signed'(term);
    assign acc_base    = clear1_reg ? init1_reg : acc_reg;
    assign acc_next    = acc_base + term_signed;

    always_ff @(posedge clk)
    begin
        if (valid1_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

>>> rtl/core/pid_motor_drive.sv
// pid_motor_drive: position PID with anti-windup, drive clamp, friction compensation
// depends on pmd_pkg, pmd_mac, pmd_div
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in      | sink      | in_valid/in_ready   | in_data   (measured, target position)
//  out     | source    | out_valid/out_ready | out_data  (drive, pwm duty, direction)
//  cfg     | sink      | cfg_write           | cfg_index, cfg_data (write only)
//
// a new beat is accepted the cycle after the result of the last one is registered,
// so the block takes no new beat while one is still running;
// the 33-step serial divider for the derivative sets the time per beat; the four
// products share one 32x32 multiplier in a two-stage multiply-accumulate unit
// reset clears the integral and the previous error and loads the register defaults
// a stalled output holds the finished beat; the next beat can run meanwhile and
// waits in its last step until the output register is free
module pid_motor_drive
    import pmd_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output out_item_t              out_data,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int AccW  = 2 * MAG_W - FRAC_BITS + 3;
    localparam int MagdW = DRIVE_INT_W + FRAC_BITS;

    localparam logic signed [AccW-1:0] IntegLim =
        AccW'(longint'(INTEG_LIMIT_INT) << FRAC_BITS);
    localparam logic signed [AccW-1:0] DriveLim =
        AccW'(longint'(DRIVE_LIMIT_INT) << FRAC_BITS);
    localparam logic [MagdW-1:0] MagLim =
        MagdW'(longint'(DRIVE_LIMIT_INT) << FRAC_BITS);
    localparam logic signed [MAG_W-1:0] IntegLim32 = MAG_W'(IntegLim);

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_INT,
        S_INT_W,
        S_INT_SAT,
        S_P,
        S_I,
        S_WDIV,
        S_D,
        S_D_W,
        S_CLAMP,
        S_FRIC,
        S_FIN
    } state_t;

    // configuration, gains kept as sign and magnitude
    logic [MAG_W-1:0]    kp_mag_reg;
    logic                kp_neg_reg;
    logic [MAG_W-1:0]    ki_mag_reg;
    logic                ki_neg_reg;
    logic [MAG_W-1:0]    kd_mag_reg;
    logic                kd_neg_reg;
    logic [MagdW-1:0]    thr_reg;
    logic [PERIOD_W-1:0] period_reg;

    logic [MAG_W-1:0]      cfg_mag;
    logic [FRICTION_W-1:0] cfg_friction;
    logic [MagdW-1:0]      thr_clamped;

    // sequencer and datapath registers
    state_t                  state_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] prev_err_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic [MAG_W-1:0]        err_mag_reg;
    logic                    err_neg_reg;
    logic signed [MAG_W-1:0] integral_reg;
    logic [MAG_W-1:0]        int_mag_reg;
    logic                    int_neg_reg;
    logic [MAG_W-1:0]        deriv_mag_reg;
    logic signed [MagdW:0]   drv_reg;
    logic [MagdW-1:0]        magf_reg;
    logic                    drvneg_reg;
    logic                    out_valid_reg;
    out_item_t               out_data_reg;

    // combinational helpers
    mac_op_t                 mac_op;
    logic signed [AccW-1:0]  mac_init;
    logic signed [AccW-1:0]  acc;
    logic                    div_start;
    logic [DIFF_W-1:0]       diff_mag;
    logic                    div_done;
    logic [MAG_W-1:0]        div_quot;
    logic signed [MAG_W-1:0] integ_clamped;
    logic signed [MagdW:0]   drv_clamped;
    logic [MagdW-1:0]        drv_mag;
    logic [MagdW-1:0]        drv_magf;
    logic signed [MagdW:0]   drive_final;
    logic                    fin_fire;

    // configuration writes
    assign cfg_mag      = cfg_data[CFG_DATA_W-1] ? (~cfg_data + 1'b1) : cfg_data;
    assign cfg_friction = cfg_data[FRICTION_W-1:0];
    assign thr_clamped  = (64'(cfg_friction) > 64'(MagLim)) ? MagLim : MagdW'(cfg_friction);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_mag_reg <= '0;
            kp_neg_reg <= 1'b0;
            ki_mag_reg <= '0;
            ki_neg_reg <= 1'b0;
            kd_mag_reg <= '0;
            kd_neg_reg <= 1'b0;
            thr_reg    <= '0;
            period_reg <= SAMPLE_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GAIN_P:
                begin
                    kp_mag_reg <= cfg_mag;
                    kp_neg_reg <= cfg_data[CFG_DATA_W-1];
                end
                REG_GAIN_I:
                begin
                    ki_mag_reg <= cfg_mag;
                    ki_neg_reg <= cfg_data[CFG_DATA_W-1];
                end
                REG_GAIN_D:
                begin
                    kd_mag_reg <= cfg_mag;
                    kd_neg_reg <= cfg_data[CFG_DATA_W-1];
                end
                REG_FRICTION:
                begin
                    thr_reg <= thr_clamped;
                end
                REG_PERIOD:
                begin
                    period_reg <= cfg_data[PERIOD_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // requests to the shared multiply-accumulate unit
    always_comb
    begin
        mac_op   = '0;
        mac_init = '0;
        unique case (state_reg)
            S_INT:
            begin
                mac_op   = '{valid: 1'b1, clear: 1'b1, neg: err_neg_reg,
                             a: err_mag_reg, b: MAG_W'(period_reg)};
                mac_init = AccW'(integral_reg);
            end
            S_P:
            begin
                mac_op = '{valid: 1'b1, clear: 1'b1, neg: kp_neg_reg ^ err_neg_reg,
                           a: kp_mag_reg, b: err_mag_reg};
            end
            S_I:
            begin
                mac_op = '{valid: 1'b1, clear: 1'b0, neg: ki_neg_reg ^ int_neg_reg,
                           a: ki_mag_reg, b: int_mag_reg};
            end
            S_D:
            begin
                mac_op = '{valid: 1'b1, clear: 1'b0, neg: kd_neg_reg ^ diff_reg[DIFF_W-1],
                           a: kd_mag_reg, b: deriv_mag_reg};
            end
            default:
            begin
            end
        endcase
    end

    pmd_mac #(
        .FRAC_BITS (FRAC_BITS),
        .ACC_W     (AccW)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mac_op),
        .init  (mac_init),
        .acc   (acc)
    );

    // derivative divider, started once the error change is known
    assign div_start = (state_reg == S_INT);
    assign diff_mag  = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);

    pmd_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .dividend_mag (diff_mag),
        .divisor      (period_reg),
        .done         (div_done),
        .quotient     (div_quot)
    );

    // anti-windup and drive clamps, friction floor
    assign integ_clamped = (acc > IntegLim)  ? MAG_W'(IntegLim)  :
                           (acc < -IntegLim) ? MAG_W'(-IntegLim) : MAG_W'(acc);
    assign drv_clamped   = (acc > DriveLim)  ? (MagdW + 1)'(DriveLim)  :
                           (acc < -DriveLim) ? (MagdW + 1)'(-DriveLim) : (MagdW + 1)'(acc);
    assign drv_mag       = drv_reg[MagdW] ? MagdW'(-drv_reg) : MagdW'(drv_reg);
    assign drv_magf      = ((drv_mag != '0) && (drv_mag < thr_reg)) ? thr_reg : drv_mag;
    assign drive_final   = drvneg_reg ? -signed'({1'b0, magf_reg}) : signed'({1'b0, magf_reg});

    // last step may load the output register
    assign fin_fire = (state_reg == S_FIN) && (!out_valid_reg || out_ready);

    // sequencer with state, loop state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !fin_fire)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        err_reg   <= ERR_W'(in_data.target_position)
                                   - ERR_W'(in_data.measured_position);
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    err_neg_reg  <= err_reg[ERR_W-1];
                    err_mag_reg  <= err_reg[ERR_W-1] ? MAG_W'(-err_reg) : MAG_W'(err_reg);
                    diff_reg     <= DIFF_W'(err_reg) - DIFF_W'(prev_err_reg);
                    prev_err_reg <= err_reg;
                    state_reg    <= S_INT;
                end
                S_INT:
                begin
                    state_reg <= S_INT_W;
                end
                S_INT_W:
                begin
                    state_reg <= S_INT_SAT;
                end
                S_INT_SAT:
                begin
                    integral_reg <= integ_clamped;
                    state_reg    <= S_P;
                end
                S_P:
                begin
                    int_neg_reg <= integral_reg[MAG_W-1];
                    int_mag_reg <= integral_reg[MAG_W-1] ? (~integral_reg + 1'b1)
                                                         : integral_reg;
                    state_reg   <= S_I;
                end
                S_I:
                begin
                    state_reg <= S_WDIV;
                end
                S_WDIV:
                begin
                    if (div_done)
                    begin
                        // positive derivative saturates one below 2^31
                        deriv_mag_reg <= (!diff_reg[DIFF_W-1] && (div_quot == QUOT_SAT))
                                       ? (QUOT_SAT - 1'b1) : div_quot;
                        state_reg     <= S_D;
                    end
                end
                S_D:
                begin
                    state_reg <= S_D_W;
                end
                S_D_W:
                begin
                    state_reg <= S_CLAMP;
                end
                S_CLAMP:
                begin
                    drv_reg   <= drv_clamped;
                    state_reg <= S_FRIC;
                end
                S_FRIC:
                begin
                    magf_reg   <= drv_magf;
                    drvneg_reg <= drv_reg[MagdW];
                    state_reg  <= S_FIN;
                end
                S_FIN:
                begin
                    if (fin_fire)
                    begin
                        out_data_reg.drive_value <= DRIVE_W'(drive_final);
                        out_data_reg.pwm_duty    <= magf_reg[FRAC_BITS+PWM_W-1:FRAC_BITS];
                        out_data_reg.dir_forward <= !drvneg_reg && (magf_reg != '0);
                        out_data_reg.dir_reverse <= drvneg_reg || (magf_reg == '0);
                        out_valid_reg            <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // integral stays inside its anti-windup window
    assert property (@(posedge clk) disable iff (!rst_n)
        (integral_reg <= IntegLim32) && (integral_reg >= -IntegLim32))
        else $error("integral outside its limit");

    // direction bits are complementary on every result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.dir_forward != out_data.dir_reverse))
        else $error("direction bits not complementary");

    // duty never exceeds the drive limit
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.pwm_duty <= PWM_W'(DRIVE_LIMIT_INT)))
        else $error("pwm duty above limit");

    // one beat at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("accepted a beat while busy");

    // derivative product only issued after the divider finished
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_D) |-> $past(div_done))
        else $error("derivative used before divide finished");

endmodule

>>> sim/pid_motor_drive_test.sv
`timescale 1ns / 1ps
// pid_motor_drive_test: self-checking bench for the position pid drive block
// depends on pmd_pkg and the pid_motor_drive rtl; drives directed rows, then random phases
module pid_motor_drive_test;
    import pmd_pkg::*;

    localparam int     FRAC          = FRAC_BITS_DEFAULT;
    localparam longint ONE           = longint'(1) << FRAC;
    localparam longint INTEG_MAX     = INTEG_LIMIT_INT * ONE;
    localparam longint DRIVE_MAX     = DRIVE_LIMIT_INT * ONE;
    localparam longint DERIV_MAX     = 64'sh7FFF_FFFF;
    localparam longint DERIV_MIN     = -(longint'(1) << 31);
    localparam int     SETTLE_CYCLES = 60;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     PHASES        = 12;
    localparam int     PHASE_BEATS   = 127;

    localparam logic signed [DRIVE_W-1:0] FULL_DRIVE = DRIVE_W'(DRIVE_LIMIT_INT << FRAC);
    localparam logic signed [DRIVE_W-1:0] UNIT_DRIVE = DRIVE_W'(1 << FRAC);

    // indexes past the register list, writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_BEYOND_FIRST = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_BEYOND_LAST  = 3'd7;

    typedef enum logic {ROW_CFG, ROW_BEAT} row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  word;
        in_item_t               beat;
        logic                   pinned;
        out_item_t              result;
    } plan_row_t;

    typedef struct packed {
        logic      pinned;
        out_item_t result;
    } pin_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_item_t              out_data;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // shadow of the block: registers and loop state
    longint kp = 0;
    longint ki = 0;
    longint kd = 0;
    longint friction = 0;
    longint period_q = longint'(SAMPLE_PERIOD_RESET);
    longint integ_acc = 0;
    longint last_err = 0;

    out_item_t drive_q[$];
    pin_t      pin_q[$];
    plan_row_t plan[$];
    int        fails = 0;
    int        gap_pct = 0;
    int        stall_pct = 0;
    int        hold_orders = 0;

    pid_motor_drive DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // run limit
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [63:0] mag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    // fixed point product, truncated toward zero
    function automatic longint q_mul(longint a, longint b);
        logic [63:0] m;
        m = (mag(a) * mag(b)) >> FRAC;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_GAIN_P:   kp = longint'(signed'(data));
            REG_GAIN_I:   ki = longint'(signed'(data));
            REG_GAIN_D:   kd = longint'(signed'(data));
            REG_FRICTION: friction = longint'(data[FRICTION_W-1:0]);
            REG_PERIOD:   period_q = longint'(data[PERIOD_W-1:0]);
            default:      ;
        endcase
    endfunction

    // one control step: integral with anti-windup, derivative, clamp, friction lift
    function automatic out_item_t predict_drive(in_item_t beat);
        longint      err;
        longint      diff;
        longint      deriv;
        longint      drive;
        longint      thr;
        logic [63:0] divisor;
        logic [63:0] quot;
        logic [63:0] whole;
        out_item_t   res;
        err = longint'(beat.target_position) - longint'(beat.measured_position);
        integ_acc = clip(integ_acc + q_mul(err, period_q), -INTEG_MAX, INTEG_MAX);
        diff = err - last_err;
        divisor = (period_q != 0) ? period_q : 1;
        quot = (mag(diff) << FRAC) / divisor;
        if (quot > 64'h8000_0000)
            quot = 64'h8000_0000;
        deriv = (diff < 0) ? -longint'(quot) : longint'(quot);
        deriv = clip(deriv, DERIV_MIN, DERIV_MAX);
        drive = q_mul(kp, err) + q_mul(ki, integ_acc) + q_mul(kd, deriv);
        drive = clip(drive, -DRIVE_MAX, DRIVE_MAX);
        last_err = err;
        thr = (friction > DRIVE_MAX) ? DRIVE_MAX : friction;
        if (drive > 0 && drive < thr)
            drive = thr;
        else if (drive < 0 && drive > -thr)
            drive = -thr;
        whole = mag(drive) >> FRAC;
        res.drive_value = drive[DRIVE_W-1:0];
        res.pwm_duty    = whole[PWM_W-1:0];
        res.dir_forward = (drive > 0);
        res.dir_reverse = !(drive > 0);
        return res;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            fails++;
        end
    endfunction

    // accept side predicts, result side compares against the oldest drive
    always @(posedge clk)
    begin : scoreboard
        out_item_t want;
        out_item_t got;
        pin_t      pin;
        if (rst_n && in_valid && in_ready)
        begin
            want = predict_drive(in_data);
            pin = pin_q.pop_front();
            drive_q.push_back(pin.pinned ? pin.result : want);
        end
        if (rst_n && out_valid && out_ready)
        begin
            got = out_data;
            if (drive_q.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none got drive %0d", $time,
                         got.drive_value);
                fails++;
            end
            else
            begin
                want = drive_q.pop_front();
                check_field("drive_value", want.drive_value, got.drive_value);
                check_field("pwm_duty", want.pwm_duty, got.pwm_duty);
                check_field("dir_forward", want.dir_forward, got.dir_forward);
                check_field("dir_reverse", want.dir_reverse, got.dir_reverse);
            end
        end
    end

    // output back-pressure, with long holds on request
    initial
    begin : receiver
        int hold_taken;
        int hold_left;
        hold_taken = 0;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_orders != hold_taken)
            begin
                hold_taken = hold_orders;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        apply_reg(idx, data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // offer one beat, hold it until taken, then maybe go idle
    task automatic send_beat(in_item_t beat, logic pinned, out_item_t result);
        pin_q.push_back({pinned, result});
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge clk);
        end
    endtask

    // drop valid and let every pending drive come back
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (drive_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic void add_cfg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        plan_row_t row;
        row = '0;
        row.kind = ROW_CFG;
        row.index = idx;
        row.word = data;
        plan.push_back(row);
    endfunction

    function automatic void add_beat(logic [31:0] meas, logic [31:0] targ);
        plan_row_t row;
        row = '0;
        row.kind = ROW_BEAT;
        row.beat.measured_position = meas;
        row.beat.target_position = targ;
        plan.push_back(row);
    endfunction

    function automatic void add_pinned(logic [31:0] meas, logic [31:0] targ,
                                       logic signed [DRIVE_W-1:0] drive, logic [PWM_W-1:0] duty,
                                       logic fwd, logic rev);
        add_beat(meas, targ);
        plan[$].pinned = 1'b1;
        plan[$].result.drive_value = drive;
        plan[$].result.pwm_duty = duty;
        plan[$].result.dir_forward = fwd;
        plan[$].result.dir_reverse = rev;
    endfunction

    function automatic logic [31:0] corner_word();
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    function automatic in_item_t random_beat();
        in_item_t    beat;
        logic [31:0] meas;
        logic [31:0] offs;
        meas = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
        offs = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        case ($urandom_range(0, 9))
            0:
            begin
                beat.measured_position = $urandom;
                beat.target_position = $urandom;
            end
            1:
            begin
                beat.measured_position = corner_word();
                beat.target_position = corner_word();
            end
            2:
            begin
                beat.measured_position = meas;
                beat.target_position = meas;
            end
            default:
            begin
                beat.measured_position = meas;
                beat.target_position = meas + offs;
            end
        endcase
        return beat;
    endfunction

    function automatic logic [31:0] pick_gain();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0;
            3:       return $urandom;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_period();
        case ($urandom_range(0, 11))
            0:       return 32'h0;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(1, 32'h7FFF_FFFF);
            3:       return 32'h1;
            default: return $urandom_range(1, 6554);
        endcase
    endfunction

    function automatic logic [31:0] pick_friction();
        case ($urandom_range(0, 7))
            0:       return 32'h0;
            1:       return $urandom_range(32'(DRIVE_MAX + 1), (1 << FRICTION_W) - 1);
            2:       return CFG_DATA_W'(DRIVE_MAX);
            default: return $urandom_range(0, 20 << FRAC);
        endcase
    endfunction

    initial
    begin : main
        plan_row_t row;
        logic      after_beat;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        after_beat = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset state: all gains zero, so no drive at any error
        add_pinned(32'h0, 32'h0, '0, '0, 1'b0, 1'b1);
        add_pinned(32'h7FFF_FFFF, 32'h8000_0000, '0, '0, 1'b0, 1'b1);
        add_pinned(32'h8000_0000, 32'h7FFF_FFFF, '0, '0, 1'b0, 1'b1);
        // unity proportional gain: clamp at both ends, exact one unit
        add_cfg(REG_GAIN_P, 32'h0001_0000);
        add_pinned(32'h0, 32'h7FFF_FFFF, FULL_DRIVE, PWM_W'(DRIVE_LIMIT_INT), 1'b1, 1'b0);
        add_pinned(32'h7FFF_FFFF, 32'h8000_0000, -FULL_DRIVE, PWM_W'(DRIVE_LIMIT_INT),
                   1'b0, 1'b1);
        add_pinned(32'h0, 32'h0, '0, '0, 1'b0, 1'b1);
        add_pinned(32'h0, 32'h0001_0000, UNIT_DRIVE, 10'd1, 1'b1, 1'b0);
        add_pinned(32'h0001_0000, 32'h0, -UNIT_DRIVE, 10'd1, 1'b0, 1'b1);
        // friction threshold past the drive limit acts as the limit; zero stays zero
        add_cfg(REG_FRICTION, 32'h03FF_FFFF);
        add_pinned(32'h0, 32'h1, FULL_DRIVE, PWM_W'(DRIVE_LIMIT_INT), 1'b1, 1'b0);
        add_pinned(32'h1, 32'h0, -FULL_DRIVE, PWM_W'(DRIVE_LIMIT_INT), 1'b0, 1'b1);
        add_pinned(32'h0, 32'h0, '0, '0, 1'b0, 1'b1);
        // zero period: no integral growth, derivative saturates on the large error steps
        add_cfg(REG_FRICTION, 32'h0001_8000);
        add_cfg(REG_GAIN_I, 32'h8000_0000);
        add_cfg(REG_GAIN_D, 32'h7FFF_FFFF);
        add_cfg(REG_PERIOD, 32'h0);
        add_beat(32'h0, 32'h5);
        add_beat(32'h5, 32'h0);
        add_beat(32'h8000_0000, 32'h7FFF_FFFF);
        add_beat(32'h7FFF_FFFF, 32'h8000_0000);
        add_beat(32'h0, 32'h0);
        // widest gains and period, integral driven into its clamp
        add_cfg(REG_PERIOD, 32'h7FFF_FFFF);
        add_cfg(REG_GAIN_P, 32'h7FFF_FFFF);
        add_cfg(REG_GAIN_I, 32'h7FFF_FFFF);
        add_cfg(REG_GAIN_D, 32'h8000_0000);
        add_cfg(REG_FRICTION, CFG_DATA_W'(DRIVE_MAX));
        add_cfg(REG_BEYOND_FIRST, 32'hFFFF_FFFF);
        add_cfg(REG_BEYOND_LAST, 32'h0);
        add_beat(32'h8000_0000, 32'h7FFF_FFFF);
        add_beat(32'h8000_0000, 32'h7FFF_FFFF);
        add_beat(32'h7FFF_FFFF, 32'h8000_0000);
        add_beat(32'h7FFF_FFFF, 32'h8000_0000);
        add_beat(32'h0, 32'h3);

        // walk the directed rows
        foreach (plan[i])
        begin
            row = plan[i];
            if (row.kind == ROW_CFG)
            begin
                if (after_beat)
                    settle();
                write_reg(row.index, row.word);
                after_beat = 1'b0;
            end
            else
            begin
                send_beat(row.beat, row.pinned, row.result);
                after_beat = 1'b1;
            end
        end

        // random phases, each with its own settings and idling mode
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p % 4)
                0:
                begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct = 45;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct = 0;
                    stall_pct = 45;
                end
                default:
                begin
                    gap_pct = 10;
                    stall_pct = 10;
                end
            endcase
            if (p == 0)
            begin
                write_reg(REG_GAIN_P, 32'h7FFF_FFFF);
                write_reg(REG_GAIN_I, 32'h7FFF_FFFF);
                write_reg(REG_GAIN_D, 32'h7FFF_FFFF);
                write_reg(REG_FRICTION, 32'h03FF_FFFF);
                write_reg(REG_PERIOD, 32'h7FFF_FFFF);
            end
            else if (p == 1)
            begin
                write_reg(REG_GAIN_P, 32'h8000_0000);
                write_reg(REG_GAIN_I, 32'h8000_0000);
                write_reg(REG_GAIN_D, 32'h8000_0000);
                write_reg(REG_FRICTION, 32'h0);
                write_reg(REG_PERIOD, 32'h1);
            end
            else
            begin
                write_reg(REG_GAIN_P, pick_gain());
                write_reg(REG_GAIN_I, pick_gain());
                write_reg(REG_GAIN_D, pick_gain());
                write_reg(REG_FRICTION, pick_friction());
                write_reg(REG_PERIOD, pick_period());
                if ($urandom_range(0, 2) == 0)
                    write_reg(CFG_INDEX_W'($urandom_range(REG_BEYOND_FIRST, REG_BEYOND_LAST)),
                              $urandom);
            end
            // long output hold so the block backs up into its input
            if (p == 4 || p == 9)
                hold_orders++;
            repeat (PHASE_BEATS) send_beat(random_beat(), 1'b0, '0);
        end

        settle();
        if (drive_q.size() != 0)
        begin
            $display("%0t: %0d drive beats never arrived", $time, drive_q.size());
            fails++;
        end
        if (fails == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
